[rtl/tlpt_pkg.sv]
// ----------------------------------------------------------------------------
// tlpt_pkg
// shared types and constants of the two-level page table updater
// ----------------------------------------------------------------------------
`default_nettype none
package tlpt_pkg;
  localparam int unsigned POOL_FRAMES_DEF = 16;
  localparam int unsigned ENTRIES_PER_TABLE = 1024;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned ENTRY_W = 23;
  localparam logic [19:0] POOL_START_RESET = 20'd256;

  typedef enum logic [1:0] {
    KIND_MAP    = 2'd0,
    KIND_UNMAP  = 2'd1,
    KIND_NEWDIR = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_PRES = 2'd1,
    ST_EXHAUST  = 2'd2
  } status_t;

  // request as queued between front and back
  typedef struct packed {
    kind_t       kind;
    logic [19:0] dir_frame;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [2:0]  attrs;
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD_PDE, S_WAIT_PDE, S_CHK_PDE, S_CLEAR, S_WR_PDE,
    S_WR_PTE, S_RD_PTE, S_WAIT_PTE, S_ZERO_PTE, S_DONE
  } bstate_t;
endpackage
`default_nettype wire

[rtl/tlpt_fifo.sv]
// ----------------------------------------------------------------------------
// tlpt_fifo
// small request queue between front end and back end
// ----------------------------------------------------------------------------
`default_nettype none
module tlpt_fifo
  import tlpt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t wdata,
  output logic      full,
  input  wire logic pop,
  output req_t      rdata,
  output logic      empty
);
  req_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(pop && !empty);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full && !pop |=> cnt == 2'd2) else $error("queue lost entry");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    empty && !push |=> empty) else $error("queue invented entry");
endmodule
`default_nettype wire

[rtl/tlpt_back.sv]
// ----------------------------------------------------------------------------
// tlpt_back
// back end: table memory, frame allocator and per-request sequencer
// ----------------------------------------------------------------------------
`default_nettype none
module tlpt_back
  import tlpt_pkg::*;
#(
  parameter int unsigned POOL_FRAMES = POOL_FRAMES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [19:0] pool_start,
  input  wire logic        q_empty,
  input  wire req_t        q_data,
  output logic             q_pop,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [31:0]      res_addr,
  output logic [1:0]       res_status,
  output logic             res_flush
);
  localparam int unsigned SLOT_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int unsigned CNT_W  = $clog2(POOL_FRAMES + 1);
  localparam int unsigned ADDR_W = SLOT_W + IDX_W;
  localparam int unsigned DEPTH  = POOL_FRAMES * ENTRIES_PER_TABLE;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [ENTRY_W-1:0] wdata;

  bstate_t state, state_next;
  req_t               req;
  logic [CNT_W-1:0]   used;
  logic [SLOT_W-1:0]  dslot, tslot;
  logic [IDX_W-1:0]   clr;
  logic [ENTRY_W-1:0] pde;
  logic               d_ok, t_ok;
  logic [19:0]        d_off, t_off;
  logic               full_pool;

  assign full_pool = (used == CNT_W'(POOL_FRAMES));
  assign d_off = req.dir_frame - pool_start;
  assign t_off = pde[22:3] - pool_start;
  assign d_ok  = ({{(32-FRAME_W){1'b0}}, d_off} < 32'(used));
  assign t_ok  = ({{(32-FRAME_W){1'b0}}, t_off} < 32'(used));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (!q_empty) state_next = S_DECODE;
      S_DECODE: begin
        unique case (req.kind) inside
          KIND_NEWDIR: state_next = full_pool ? S_DONE : S_CLEAR;
          KIND_MAP, KIND_UNMAP: state_next = d_ok ? S_RD_PDE : S_DONE;
          default: state_next = S_DONE;
        endcase
      end
      S_RD_PDE:   state_next = S_WAIT_PDE;
      S_WAIT_PDE: state_next = S_CHK_PDE;
      S_CHK_PDE: begin
        if (!pde[0]) begin
          if (req.kind == KIND_UNMAP || full_pool) state_next = S_DONE;
          else state_next = S_CLEAR;
        end else if (!t_ok) state_next = S_DONE;
        else if (req.kind == KIND_MAP) state_next = S_WR_PTE;
        else state_next = S_RD_PTE;
      end
      S_CLEAR: begin
        if (clr == IDX_W'(ENTRIES_PER_TABLE - 1))
          state_next = (req.kind == KIND_NEWDIR) ? S_DONE : S_WR_PDE;
      end
      S_WR_PDE:   state_next = S_WR_PTE;
      S_WR_PTE:   state_next = S_DONE;
      S_RD_PTE:   state_next = S_WAIT_PTE;
      S_WAIT_PTE: state_next = S_ZERO_PTE;
      S_ZERO_PTE: state_next = S_DONE;
      S_DONE:     if (res_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = {dslot, req.virt_addr[31:22]};
    q_pop = (state == S_IDLE) && !q_empty;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1; waddr = {used[SLOT_W-1:0], clr};
      end
      S_WR_PDE: begin
        we = 1'b1; waddr = {dslot, req.virt_addr[31:22]};
        wdata = {pool_start + 20'(used - CNT_W'(1)), req.attrs};
      end
      S_WR_PTE: begin
        we = 1'b1; waddr = {tslot, req.virt_addr[21:12]};
        wdata = {req.phys_addr[31:12], req.attrs};
      end
      S_RD_PTE: raddr = {tslot, req.virt_addr[21:12]};
      S_ZERO_PTE: begin
        we = 1'b1; waddr = {tslot, req.virt_addr[21:12]};
      end
      default: ;
    endcase
  end

  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR && clr == IDX_W'(ENTRIES_PER_TABLE - 1))
        used <= used + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req <= q_data;
        clr <= '0;
        res_addr <= '0; res_status <= ST_OK; res_flush <= 1'b0;
      end
      S_DECODE: begin
        dslot <= d_off[SLOT_W-1:0];
        if (req.kind == KIND_NEWDIR && full_pool) res_status <= ST_EXHAUST;
        if ((req.kind == KIND_MAP || req.kind == KIND_UNMAP) && !d_ok)
          res_status <= ST_NOT_PRES;
        if (req.kind == KIND_NEWDIR && !full_pool)
          res_addr <= {pool_start + 20'(used), 12'h000};
      end
      S_WAIT_PDE: pde <= rd_data;
      S_CHK_PDE: begin
        if (!pde[0]) begin
          if (req.kind == KIND_UNMAP) res_status <= ST_NOT_PRES;
          else if (full_pool) res_status <= ST_EXHAUST;
          else tslot <= used[SLOT_W-1:0];
        end else begin
          tslot <= t_off[SLOT_W-1:0];
          if (!t_ok) res_status <= ST_NOT_PRES;
        end
      end
      S_CLEAR: clr <= clr + IDX_W'(1);
      S_WR_PTE: res_flush <= 1'b1;
      S_WAIT_PTE: begin
        res_addr  <= {rd_data[22:3], req.virt_addr[11:0]};
        res_flush <= 1'b1;
      end
      default: ;
    endcase
  end

  a_used_max: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(POOL_FRAMES)) else $error("pool count overflow");
  a_flush_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_flush |-> res_status == ST_OK) else $error("flush on error");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_addr))
    else $error("result dropped");
endmodule
`default_nettype wire

[rtl/two_level_page_table_updater_core.sv]
// ----------------------------------------------------------------------------
// two_level_page_table_updater_core
// map, unmap and new-directory engine over a pool of page table frames
// ----------------------------------------------------------------------------
// requests come in on valid/ready; a two-entry queue lets the front take
// requests while the back end works on the previous one.
// one result per request on res valid/ready, held until taken.
// clearing a newly allocated frame writes all 1024 entries, one entry a cycle
// through the single write port of the table memory. requests are handled one
// at a time by the back-end sequencer.
// reset (rst, synchronous) empties the queue and the pool; table contents
// are not cleared, every frame is cleared when allocated.
// a stalled receiver holds the back end in its result state; the queue
// keeps accepting until full. pool_start is written through cfg_we.
// ----------------------------------------------------------------------------
`default_nettype none
module two_level_page_table_updater_core
  import tlpt_pkg::*;
#(
  parameter int unsigned POOL_FRAMES = POOL_FRAMES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [19:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [19:0] dir_frame,
  input  wire logic [31:0] virt_addr,
  input  wire logic [31:0] phys_addr,
  input  wire logic [2:0]  attrs,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_addr,
  output logic [1:0]       status,
  output logic             tlb_flush
);
  logic [19:0] pool_start;
  req_t        q_in, q_out;
  logic        q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (rst) pool_start <= POOL_START_RESET;
    else if (cfg_we) pool_start <= cfg_wdata;
  end

  // front: classify kind into the queued request
  always_comb begin
    q_in.kind      = kind_t'(kind);
    q_in.dir_frame = dir_frame;
    q_in.virt_addr = virt_addr;
    q_in.phys_addr = phys_addr;
    q_in.attrs     = attrs;
  end
  assign in_ready = !q_full;

  tlpt_fifo u_fifo (
    .clk(clk), .rst(rst), .push(in_valid), .wdata(q_in), .full(q_full),
    .pop(q_pop), .rdata(q_out), .empty(q_empty)
  );

  tlpt_back #(.POOL_FRAMES(POOL_FRAMES)) u_back (
    .clk(clk), .rst(rst), .pool_start(pool_start), .q_empty(q_empty),
    .q_data(q_out), .q_pop(q_pop), .res_valid(out_valid),
    .res_ready(out_ready), .res_addr(result_addr), .res_status(status),
    .res_flush(tlb_flush)
  );
endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-level page table updater: directed and
// random map, unmap and new-directory requests under several pool start frames,
// with back-pressure on both sides, checked against an in-bench table model
// ----------------------------------------------------------------------------
module tb_top;
  import tlpt_pkg::*;

  localparam int unsigned NFRAMES = 16;
  localparam int unsigned STALL_LIMIT = 6000;

  typedef struct packed {
    logic [31:0] addr;
    status_t     st;
    logic        flush;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [19:0] dir_frame = '0;
  logic [31:0] virt_addr = '0;
  logic [31:0] phys_addr = '0;
  logic [2:0]  attrs = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_addr;
  logic [1:0]  status;
  logic        tlb_flush;

  two_level_page_table_updater_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .dir_frame(dir_frame),
    .virt_addr(virt_addr), .phys_addr(phys_addr), .attrs(attrs),
    .out_valid(out_valid), .out_ready(out_ready), .result_addr(result_addr),
    .status(status), .tlb_flush(tlb_flush)
  );

  always #10 clk = ~clk;

  // model state
  logic [22:0] tbl_mem [NFRAMES*ENTRIES_PER_TABLE];
  int unsigned frames_taken = 0;
  logic [19:0] pool_base = POOL_START_RESET;

  req_t    pending_reqs[$];
  answer_t expected_answers[$];
  int unsigned send_idle = 0, recv_idle = 0;
  int unsigned hold_trig = 0, hold_seen = 0, hold_left = 0;
  int unsigned errors = 0, accepted = 0, answered = 0;
  int unsigned n_flush = 0, n_exhaust = 0, n_notpres = 0;
  int unsigned stall_cnt = 0;
  int unsigned gen_newdirs = 0;
  logic [19:0] gen_base = POOL_START_RESET;

  // slot of a frame in the pool, NFRAMES if not handed out
  function automatic int unsigned pool_slot(logic [19:0] frame);
    logic [19:0] s;
    s = frame - pool_base;
    return (s < frames_taken) ? int'(s) : NFRAMES;
  endfunction

  function automatic int unsigned grab_frame();
    int unsigned s;
    s = frames_taken;
    for (int i = 0; i < ENTRIES_PER_TABLE; i++) tbl_mem[s*ENTRIES_PER_TABLE+i] = '0;
    frames_taken = s + 1;
    return s;
  endfunction

  function automatic answer_t apply_request(req_t r);
    answer_t a;
    int unsigned ds, ts, pidx, tidx;
    logic [22:0] pde;
    logic [9:0] di, ti;
    logic [19:0] fr;
    a = '{addr: '0, st: ST_OK, flush: 1'b0};
    di = r.virt_addr[31:22];
    ti = r.virt_addr[21:12];
    case (r.kind)
      KIND_NEWDIR: begin
        if (frames_taken >= NFRAMES) a.st = ST_EXHAUST;
        else begin
          fr = pool_base + 20'(grab_frame());
          a.addr = {fr, 12'h000};
        end
      end
      KIND_MAP, KIND_UNMAP: begin
        ds = pool_slot(r.dir_frame);
        if (ds >= NFRAMES) return '{addr: '0, st: ST_NOT_PRES, flush: 1'b0};
        pidx = ds*ENTRIES_PER_TABLE + di;
        pde = tbl_mem[pidx];
        if (r.kind == KIND_MAP) begin
          if (!pde[0]) begin
            if (frames_taken >= NFRAMES) return '{addr: '0, st: ST_EXHAUST, flush: 1'b0};
            ts = grab_frame();
            fr = pool_base + 20'(ts);
            tbl_mem[pidx] = {fr, r.attrs};
          end else begin
            ts = pool_slot(pde[22:3]);
            if (ts >= NFRAMES) return '{addr: '0, st: ST_NOT_PRES, flush: 1'b0};
          end
          tbl_mem[ts*ENTRIES_PER_TABLE + ti] = {r.phys_addr[31:12], r.attrs};
          a.flush = 1'b1;
        end else begin
          if (!pde[0]) return '{addr: '0, st: ST_NOT_PRES, flush: 1'b0};
          ts = pool_slot(pde[22:3]);
          if (ts >= NFRAMES) return '{addr: '0, st: ST_NOT_PRES, flush: 1'b0};
          tidx = ts*ENTRIES_PER_TABLE + ti;
          a.addr = {tbl_mem[tidx][22:3], 12'h000} + {20'h0, r.virt_addr[11:0]};
          tbl_mem[tidx] = '0;
          a.flush = 1'b1;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic req_t mk_req(kind_t k, logic [19:0] d, logic [31:0] v,
                                  logic [31:0] p, logic [2:0] at);
    req_t r;
    r.kind = k; r.dir_frame = d; r.virt_addr = v; r.phys_addr = p; r.attrs = at;
    return r;
  endfunction

  // mostly hits on a few directory and table slots, some fully random noise
  function automatic req_t rand_request();
    req_t r;
    int unsigned pick, span;
    logic [9:0] di_set [4] = '{10'd0, 10'd1, 10'd2, 10'd1023};
    pick = $urandom_range(0, 99);
    if (pick < 46) r.kind = KIND_MAP;
    else if (pick < 90) r.kind = KIND_UNMAP;
    else if (pick < 95) r.kind = KIND_NEWDIR;
    else r.kind = KIND_NONE;
    if (r.kind == KIND_NEWDIR) gen_newdirs++;
    span = (2*gen_newdirs > NFRAMES-1) ? NFRAMES-1 : 2*gen_newdirs;
    if ($urandom_range(0, 9) < 8) r.dir_frame = gen_base + 20'($urandom_range(0, span));
    else r.dir_frame = 20'($urandom);
    if ($urandom_range(0, 9) < 8)
      r.virt_addr = {di_set[$urandom_range(0, 3)], 10'($urandom_range(0, 3)),
                     12'($urandom)};
    else r.virt_addr = $urandom;
    r.phys_addr = $urandom;
    r.attrs = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) != 0) r.attrs[0] = 1'b1;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_pool_base(logic [19:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_base = v;
    gen_base = v;
    gen_newdirs = NFRAMES;
  endtask

  // request driver
  always @(posedge clk) begin
    answer_t a;
    req_t r;
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) begin
        r = mk_req(kind_t'(kind), dir_frame, virt_addr, phys_addr, attrs);
        a = apply_request(r);
        expected_answers.push_back(a);
        accepted++;
      end
      if (!in_valid || take) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          r = pending_reqs.pop_front();
          kind <= r.kind;
          dir_frame <= r.dir_frame;
          virt_addr <= r.virt_addr;
          phys_addr <= r.phys_addr;
          attrs <= r.attrs;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    answer_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        answered++;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result addr=%h status=%0d flush=%b", $time,
                   result_addr, status, tlb_flush);
          errors++;
        end else begin
          e = expected_answers.pop_front();
          if (result_addr !== e.addr) begin
            $display("%0t: result_addr expected %h actual %h", $time, e.addr, result_addr);
            errors++;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
          if (tlb_flush !== e.flush) begin
            $display("%0t: tlb_flush expected %b actual %b", $time, e.flush, tlb_flush);
            errors++;
          end
          if (e.flush) n_flush++;
          if (e.st == ST_EXHAUST) n_exhaust++;
          if (e.st == ST_NOT_PRES) n_notpres++;
        end
      end
      if (hold_trig != hold_seen) begin
        hold_seen <= hold_trig;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt == STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cnt);
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    logic [19:0] a0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 7;
    recv_idle = 55;

    // base near the top so pool frame numbers wrap past 0xfffff
    write_pool_base(20'hffff8);
    a0 = 20'hffff8;
    pending_reqs.push_back(mk_req(KIND_NEWDIR, '0, '0, '0, '0));
    pending_reqs.push_back(mk_req(KIND_UNMAP, a0, 32'h0, '0, 3'd7));
    pending_reqs.push_back(mk_req(KIND_MAP, a0, 32'h0, 32'hffffffff, 3'd7));
    pending_reqs.push_back(mk_req(KIND_UNMAP, a0, 32'h00000fff, '0, '0));
    // entry already cleared: still answers with frame zero plus offset
    pending_reqs.push_back(mk_req(KIND_UNMAP, a0, 32'h00000123, '0, '0));
    // table allocated with a non-present directory entry
    pending_reqs.push_back(mk_req(KIND_MAP, a0, 32'hffffffff, 32'h0, 3'd0));
    pending_reqs.push_back(mk_req(KIND_MAP, a0, 32'hfffff000, 32'h12345000, 3'd1));
    pending_reqs.push_back(mk_req(KIND_UNMAP, a0, 32'hfffffabc, '0, '0));
    pending_reqs.push_back(mk_req(KIND_MAP, a0, 32'h00401000, 32'hfffff000, 3'd3));
    pending_reqs.push_back(mk_req(KIND_UNMAP, a0, 32'h00401fff, '0, '0));
    // frames outside the handed-out part of the pool
    pending_reqs.push_back(mk_req(KIND_MAP, 20'h00000, 32'h0, 32'h1000, 3'd7));
    pending_reqs.push_back(mk_req(KIND_UNMAP, 20'hfffff, 32'h0, '0, '0));
    pending_reqs.push_back(mk_req(KIND_NONE, 20'hfffff, 32'hffffffff, 32'hffffffff, 3'd7));
    for (int i = 0; i < 5; i++) pending_reqs.push_back(mk_req(KIND_NEWDIR, '0, '0, '0, '0));
    // directory frame that wrapped to zero
    pending_reqs.push_back(mk_req(KIND_MAP, 20'h00000, 32'h80000000, 32'habcde000, 3'd7));
    pending_reqs.push_back(mk_req(KIND_UNMAP, 20'h00000, 32'h80000777, '0, '0));
    // a table frame used as a directory
    pending_reqs.push_back(mk_req(KIND_MAP, 20'hffff9, 32'h00c00000, 32'h5000, 3'd5));
    gen_newdirs = 8;
    for (int i = 0; i < 120; i++) pending_reqs.push_back(rand_request());
    wait_drained();
    // receiver holds off while the sender keeps offering
    hold_trig++;
    for (int i = 0; i < 130; i++) pending_reqs.push_back(rand_request());

    write_pool_base(20'h00000);
    send_idle = 55;
    recv_idle = 7;
    for (int i = 0; i < 120; i++) pending_reqs.push_back(rand_request());
    // sender pause until every result is back
    wait_drained();
    for (int i = 0; i < 130; i++) pending_reqs.push_back(rand_request());

    write_pool_base(20'($urandom));
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_request());

    write_pool_base(20'hfffff);
    for (int i = 0; i < 150; i++) pending_reqs.push_back(rand_request());

    wait_drained();
    repeat (40) @(posedge clk);
    $display("run covered %0d requests, %0d results: %0d flushes, %0d not present,",
             accepted, answered, n_flush, n_notpres);
    $display("%0d pool exhausted, pool base swept over 0xffff8, 0, random, 0xfffff",
             n_exhaust);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
